// ----- design/ljpf_pkg.sv -----
`timescale 1ns / 1ps
package ljpf_pkg;

  localparam int unsigned DISP_FRAC_BITS = 24;
  localparam int unsigned ATOM_COUNT = 4096;
  localparam int unsigned INDEX_W = 12;
  localparam int unsigned DISP_W = 32;
  localparam int unsigned OUT_W = 48;
  localparam int unsigned CFG_W = 48;
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned DEFAULT_QUEUE_DEPTH = 4;
  localparam int unsigned RESULT_QUEUE_DEPTH = 2;

  // pipeline depths of the datapath units
  localparam int unsigned MUL_LAT = 3;
  localparam int unsigned DIV_LAT = 65;

  // floor(x/3) = (x * ceil(2^65/3)) >> 65 for any 64 bit x
  localparam logic [63:0] DIV3_MAGIC = 64'hAAAA_AAAA_AAAA_AAAB;
  localparam int unsigned DIV3_SHIFT = 65;

  // register indexes of the configuration port
  localparam logic [CFG_INDEX_W-1:0] REG_C6_SCALED = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_C12_SCALED = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_CUTOFF_SQ = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_ENERGY_SHIFT = 2'd3;

  typedef struct packed {
    logic [INDEX_W-1:0] atom_i;
    logic [INDEX_W-1:0] atom_j;
    logic signed [DISP_W-1:0] disp_x;
    logic signed [DISP_W-1:0] disp_y;
    logic signed [DISP_W-1:0] disp_z;
  } pair_t;

  typedef struct packed {
    logic pair_used;
    logic [INDEX_W-1:0] index_i;
    logic [INDEX_W-1:0] index_j;
    logic signed [OUT_W-1:0] pair_energy;
    logic signed [OUT_W-1:0] force_x;
    logic signed [OUT_W-1:0] force_y;
    logic signed [OUT_W-1:0] force_z;
  } result_t;

  typedef struct packed {
    logic [47:0] c6_scaled;
    logic [47:0] c12_scaled;
    logic [31:0] cutoff_sq;
    logic signed [47:0] energy_shift;
  } cfg_t;

  // what the front hands to the back for one pair
  typedef struct packed {
    logic used;
    logic [INDEX_W-1:0] atom_i;
    logic [INDEX_W-1:0] atom_j;
    logic [2:0] dneg;
    logic [2:0][DISP_W-1:0] dabs;
  } ctx_t;

  typedef struct packed {
    ctx_t ctx;
    logic [63:0] r2q;
  } job_t;

endpackage

// ----- design/ljpf_fifo.sv -----
`timescale 1ns / 1ps
module ljpf_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic do_wr;
  logic do_rd;

  assign full = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign do_wr = wr_en && !full;
  assign do_rd = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end
endmodule

// ----- design/ljpf_delay.sv -----
`timescale 1ns / 1ps
module ljpf_delay #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WIDTH-1:0] din,
  output logic [WIDTH-1:0] dout
);
  logic [WIDTH-1:0] taps [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      taps[0] <= din;
      for (int k = 1; k < DEPTH; k++) begin
        taps[k] <= taps[k-1];
      end
    end
  end

  assign dout = taps[DEPTH-1];
endmodule

// ----- design/ljpf_mul.sv -----
`timescale 1ns / 1ps
// 64x64 product shifted right by SH, saturating to all ones
module ljpf_mul #(
  parameter int unsigned SH = 32
) (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic [63:0] p
);
  logic [63:0] p00;
  logic [63:0] p01;
  logic [63:0] p10;
  logic [63:0] p11;
  logic [127:0] prod;
  logic [127:0] shifted;

  assign shifted = prod >> SH;

  always_ff @(posedge clk) begin
    if (en) begin
      // 32x32 partial products
      p00 <= a[31:0] * b[31:0];
      p01 <= a[31:0] * b[63:32];
      p10 <= a[63:32] * b[31:0];
      p11 <= a[63:32] * b[63:32];
      prod <= {p11, 64'b0} + {32'b0, p01, 32'b0} + {32'b0, p10, 32'b0} + {64'b0, p00};
      p <= (|shifted[127:64]) ? '1 : shifted[63:0];
    end
  end
endmodule

// ----- design/ljpf_div.sv -----
`timescale 1ns / 1ps
// floor(2^64 / r2q), all ones for r2q of zero or one; one quotient bit per stage
module ljpf_div (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] r2q,
  output logic [63:0] rinv2
);
  import ljpf_pkg::*;

  logic [63:0] rem [DIV_LAT];
  logic [63:0] quo [DIV_LAT];
  logic [63:0] dsr [DIV_LAT];
  logic        sat [DIV_LAT];

  for (genvar k = 0; k < DIV_LAT; k++) begin : g_step
    logic [63:0] rem_in;
    logic [63:0] quo_in;
    logic [63:0] dsr_in;
    logic        sat_in;
    logic [64:0] trial;
    logic        ge;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign quo_in = '0;
      assign sat_in = (r2q <= 64'd1);
      assign dsr_in = (r2q <= 64'd1) ? 64'd2 : r2q;
      // dividend 2^64: only the top bit is set
      assign trial = {rem_in, 1'b1};
    end else begin : g_next
      assign rem_in = rem[k-1];
      assign quo_in = quo[k-1];
      assign sat_in = sat[k-1];
      assign dsr_in = dsr[k-1];
      assign trial = {rem_in, 1'b0};
    end

    assign ge = (trial >= {1'b0, dsr_in});

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k] <= ge ? 64'(trial - {1'b0, dsr_in}) : trial[63:0];
        quo[k] <= {quo_in[62:0], ge};
        dsr[k] <= dsr_in;
        sat[k] <= sat_in;
      end
    end
  end

  assign rinv2 = sat[DIV_LAT-1] ? '1 : quo[DIV_LAT-1];
endmodule

// ----- design/ljpf_front.sv -----
`timescale 1ns / 1ps
module ljpf_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  ljpf_pkg::pair_t  pair,
  output logic             full,
  input  logic [31:0]      cutoff_sq,
  output logic             job_valid,
  output ljpf_pkg::job_t   job,
  input  logic             job_ready
);
  import ljpf_pkg::*;

  localparam int R2_SHIFT = 2 * int'(DISP_FRAC_BITS) - 32;

  logic fen;
  logic f1_valid;
  pair_t f1_pair;
  logic f2_valid;
  ctx_t f2_ctx;
  logic [2:0][63:0] f2_sq;

  logic [2:0] d_neg;
  logic [2:0][DISP_W-1:0] d_abs;
  logic [2:0][DISP_W-1:0] d_raw;
  logic [63:0] r2_sum;
  logic [63:0] r2q;
  logic idx_ok;

  assign fen = !f2_valid || job_ready;
  assign full = !fen;

  assign d_raw[0] = f1_pair.disp_x;
  assign d_raw[1] = f1_pair.disp_y;
  assign d_raw[2] = f1_pair.disp_z;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      d_neg[k] = d_raw[k][DISP_W-1];
      d_abs[k] = d_neg[k] ? DISP_W'(-d_raw[k]) : d_raw[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
      f2_valid <= 1'b0;
    end else if (fen) begin
      f1_valid <= push;
      f2_valid <= f1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fen) begin
      f1_pair <= pair;
      f2_ctx.used <= 1'b0;
      f2_ctx.atom_i <= f1_pair.atom_i;
      f2_ctx.atom_j <= f1_pair.atom_j;
      f2_ctx.dneg <= d_neg;
      f2_ctx.dabs <= d_abs;
      for (int k = 0; k < 3; k++) begin
        f2_sq[k] <= d_abs[k] * d_abs[k];
      end
    end
  end

  // each square is at most 2^62, so the sum fits 64 bits
  assign r2_sum = f2_sq[0] + f2_sq[1] + f2_sq[2];

  if (R2_SHIFT >= 0) begin : g_rshift
    assign r2q = r2_sum >> R2_SHIFT;
  end else begin : g_lshift
    localparam int LS = -R2_SHIFT;
    assign r2q = (r2_sum > ({64{1'b1}} >> LS)) ? '1 : (r2_sum << LS);
  end

  assign idx_ok = (f2_ctx.atom_j >= f2_ctx.atom_i)
               && (32'(f2_ctx.atom_i) < ATOM_COUNT)
               && (32'(f2_ctx.atom_j) < ATOM_COUNT);

  always_comb begin
    job.ctx = f2_ctx;
    job.ctx.used = idx_ok && (r2q < {16'b0, cutoff_sq, 16'b0});
    job.r2q = r2q;
  end

  assign job_valid = f2_valid;
endmodule

// ----- design/ljpf_back.sv -----
`timescale 1ns / 1ps
module ljpf_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  ljpf_pkg::job_t    in_job,
  input  ljpf_pkg::cfg_t    cfg,
  output logic              out_valid,
  output ljpf_pkg::result_t out_item
);
  import ljpf_pkg::*;

  localparam int unsigned L_R2 = DIV_LAT;
  localparam int unsigned L_M1 = L_R2 + MUL_LAT;
  localparam int unsigned L_R6 = L_M1 + MUL_LAT;
  localparam int unsigned L_R12 = L_R6 + MUL_LAT;
  localparam int unsigned L_V12 = L_R12 + MUL_LAT;
  localparam int unsigned L_G = L_V12 + 1;
  localparam int unsigned L_AF = L_G + MUL_LAT;
  localparam int unsigned L_E = L_AF + 1;
  localparam int unsigned L_F = L_AF + MUL_LAT;
  localparam int unsigned FSHIFT = DISP_FRAC_BITS + 8;
  localparam logic signed [63:0] MAX48 = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [63:0] MIN48 = -64'sh0000_8000_0000_0000;

  logic [L_F-1:0] vpipe;
  logic [63:0] rinv2;
  logic [63:0] rinv2_m2;
  logic [63:0] rinv2_af;
  logic [63:0] rinv4;
  logic [63:0] rinv6;
  logic [63:0] rinv12;
  logic [63:0] v6;
  logic [63:0] v6_d;
  logic [63:0] v12;
  logic g_neg;
  logic [63:0] g_mag;
  logic [63:0] v12_q;
  logic [63:0] v6_q;
  logic [63:0] e12;
  logic [63:0] e6;
  logic [63:0] af_mag;
  logic signed [63:0] e_diff;
  logic signed [63:0] e_floor;
  logic signed [63:0] e_rel;
  logic signed [OUT_W-1:0] e_sat;
  logic [OUT_W-1:0] e_out;
  logic g_neg_out;
  logic [2:0][DISP_W-1:0] dabs_af;
  logic [2:0][63:0] f_mag;
  ctx_t ctx_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else if (en) begin
      vpipe <= {vpipe[L_F-2:0], in_valid};
    end
  end
  assign out_valid = vpipe[L_F-1];

  ljpf_div u_div (.clk, .en, .r2q(in_job.r2q), .rinv2);

  ljpf_delay #(.WIDTH(64), .DEPTH(MUL_LAT)) u_dly_r2a (
    .clk, .en, .din(rinv2), .dout(rinv2_m2));
  ljpf_delay #(.WIDTH(64), .DEPTH(L_G - L_R2)) u_dly_r2b (
    .clk, .en, .din(rinv2), .dout(rinv2_af));

  // inverse powers of r
  ljpf_mul #(.SH(32)) u_m1 (.clk, .en, .a(rinv2), .b(rinv2), .p(rinv4));
  ljpf_mul #(.SH(32)) u_m2 (.clk, .en, .a(rinv4), .b(rinv2_m2), .p(rinv6));
  ljpf_mul #(.SH(32)) u_m3 (.clk, .en, .a(rinv6), .b(rinv6), .p(rinv12));
  ljpf_mul #(.SH(32)) u_v6 (.clk, .en, .a({16'b0, cfg.c6_scaled}), .b(rinv6), .p(v6));
  ljpf_mul #(.SH(32)) u_v12 (.clk, .en, .a({16'b0, cfg.c12_scaled}), .b(rinv12), .p(v12));

  ljpf_delay #(.WIDTH(64), .DEPTH(L_V12 - L_R12)) u_dly_v6 (
    .clk, .en, .din(v6), .dout(v6_d));

  always_ff @(posedge clk) begin
    if (en) begin
      g_neg <= v6_d > v12;
      g_mag <= (v6_d > v12) ? v6_d - v12 : v12 - v6_d;
      v12_q <= v12 >> 2;
      v6_q <= v6_d >> 1;
    end
  end

  // v12/12 and v6/6 through a divide by three
  ljpf_mul #(.SH(DIV3_SHIFT)) u_d12 (.clk, .en, .a(v12_q), .b(DIV3_MAGIC), .p(e12));
  ljpf_mul #(.SH(DIV3_SHIFT)) u_d6 (.clk, .en, .a(v6_q), .b(DIV3_MAGIC), .p(e6));
  ljpf_mul #(.SH(32)) u_af (.clk, .en, .a(g_mag), .b(rinv2_af), .p(af_mag));

  // both quotients stay below 2^62
  assign e_diff = $signed(e12) - $signed(e6);
  assign e_floor = e_diff >>> 8;
  assign e_rel = e_floor - {{16{cfg.energy_shift[47]}}, cfg.energy_shift};

  always_ff @(posedge clk) begin
    if (en) begin
      if (e_rel > MAX48) begin
        e_sat <= OUT_W'(MAX48);
      end else if (e_rel < MIN48) begin
        e_sat <= OUT_W'(MIN48);
      end else begin
        e_sat <= OUT_W'(e_rel);
      end
    end
  end

  ljpf_delay #(.WIDTH(OUT_W), .DEPTH(L_F - L_E)) u_dly_e (
    .clk, .en, .din(e_sat), .dout(e_out));
  ljpf_delay #(.WIDTH(1), .DEPTH(L_F - L_G)) u_dly_g (
    .clk, .en, .din(g_neg), .dout(g_neg_out));
  ljpf_delay #(.WIDTH(3 * DISP_W), .DEPTH(L_AF)) u_dly_d (
    .clk, .en, .din(in_job.ctx.dabs), .dout(dabs_af));
  ljpf_delay #(.WIDTH($bits(ctx_t)), .DEPTH(L_F)) u_dly_ctx (
    .clk, .en, .din(in_job.ctx), .dout(ctx_out));

  for (genvar k = 0; k < 3; k++) begin : g_force
    ljpf_mul #(.SH(FSHIFT)) u_f (
      .clk, .en, .a(af_mag), .b({32'b0, dabs_af[k]}), .p(f_mag[k]));
  end

  function automatic logic [OUT_W-1:0] signed_sat(input logic [63:0] mag, input logic neg);
    logic [OUT_W-1:0] res;
    if (neg) begin
      res = (mag >= 64'h0000_8000_0000_0000) ? OUT_W'(MIN48) : OUT_W'(-mag);
    end else begin
      res = (mag > 64'(MAX48)) ? OUT_W'(MAX48) : OUT_W'(mag);
    end
    return res;
  endfunction

  always_comb begin
    out_item.pair_used = ctx_out.used;
    out_item.index_i = ctx_out.atom_i;
    out_item.index_j = ctx_out.atom_j;
    out_item.pair_energy = '0;
    out_item.force_x = '0;
    out_item.force_y = '0;
    out_item.force_z = '0;
    if (ctx_out.used) begin
      out_item.pair_energy = e_out;
      out_item.force_x = signed_sat(f_mag[0], g_neg_out ^ ctx_out.dneg[0]);
      out_item.force_y = signed_sat(f_mag[1], g_neg_out ^ ctx_out.dneg[1]);
      out_item.force_z = signed_sat(f_mag[2], g_neg_out ^ ctx_out.dneg[2]);
    end
  end
endmodule

// ----- design/lennard_jones_pair_force.sv -----
`timescale 1ns / 1ps
// Shifted 12-6 Lennard-Jones pair force unit. Each request is one neighbour pair
// (two atom indices and the displacement i minus j); each gives exactly one result,
// in order: the two indices, a used flag, the shifted pair energy and the force on
// atom i, with energy and force zero for a dropped pair (j below i or r^2 at or past
// the cutoff). One pair enters per clock while the result side keeps popping. A pair
// passes a second front stage, the job queue, the 65-stage reciprocal divider, four
// chained 3-stage multipliers (r^-4, r^-6, r^-12, repulsion term), a registered compare,
// two more 3-stage multipliers for the force, and the write into the result queue.
// Configuration registers are to be written by the user only while no pair is in
// flight; the block itself does not enforce this.
module lennard_jones_pair_force #(
  parameter int unsigned QUEUE_DEPTH = ljpf_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // request side
  input  logic                                 push,
  input  ljpf_pkg::pair_t                      pair,
  output logic                                 full,
  // result side
  output logic                                 empty,
  input  logic                                 pop,
  output ljpf_pkg::result_t                    result,
  // configuration writes
  input  logic                                 cfg_we,
  input  logic [ljpf_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [ljpf_pkg::CFG_W-1:0]           cfg_data
);
  import ljpf_pkg::*;

  cfg_t cfg;

  // front to back queue
  logic   job_valid;
  job_t   job;
  logic   jq_full;
  logic   jq_empty;
  job_t   jq_head;
  logic   jq_pop;

  // back pipeline and result queue
  logic    adv;
  logic    res_valid;
  result_t res_item;
  logic    rq_full;

  // register file; the user writes it only while idle, the block does not enforce this
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_C6_SCALED:    cfg.c6_scaled <= cfg_data;
        REG_C12_SCALED:   cfg.c12_scaled <= cfg_data;
        REG_CUTOFF_SQ:    cfg.cutoff_sq <= cfg_data[31:0];
        REG_ENERGY_SHIFT: cfg.energy_shift <= cfg_data;
        default: ;
      endcase
    end
  end

  // front: takes the request, squares the displacement, classifies the pair
  ljpf_front u_front (
    .clk,
    .rst,
    .push,
    .pair,
    .full,
    .cutoff_sq(cfg.cutoff_sq),
    .job_valid,
    .job,
    .job_ready(!jq_full)
  );

  // short queue so front and back stall independently
  ljpf_fifo #(.WIDTH($bits(job_t)), .DEPTH(QUEUE_DEPTH)) u_job_q (
    .clk,
    .rst,
    .wr_en(job_valid),
    .wr_data(job),
    .rd_en(jq_pop),
    .rd_data(jq_head),
    .full(jq_full),
    .empty(jq_empty)
  );

  // whole back pipeline moves together; it holds only when a finished
  // result cannot be parked in the result queue
  assign adv = !res_valid || !rq_full;
  assign jq_pop = adv && !jq_empty;

  ljpf_back u_back (
    .clk,
    .rst,
    .en(adv),
    .in_valid(jq_pop),
    .in_job(jq_head),
    .cfg,
    .out_valid(res_valid),
    .out_item(res_item)
  );

  // result queue: a new result lands while the oldest one waits
  ljpf_fifo #(.WIDTH($bits(result_t)), .DEPTH(RESULT_QUEUE_DEPTH)) u_res_q (
    .clk,
    .rst,
    .wr_en(res_valid && adv),
    .wr_data(res_item),
    .rd_en(pop),
    .rd_data(result),
    .full(rq_full),
    .empty
  );
endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
module tb;
  import ljpf_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  pair_t pair = '0;
  logic full;
  logic empty;
  logic pop = 1'b0;
  result_t result;
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = REG_C6_SCALED;
  logic [CFG_W-1:0] cfg_data = '0;

  lennard_jones_pair_force uut (
    .clk(clk), .rst(rst),
    .push(push), .pair(pair), .full(full),
    .empty(empty), .pop(pop), .result(result),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // shadow copy of the register file, updated on every write
  logic [47:0] c6_reg = '0;
  logic [47:0] c12_reg = '0;
  logic [31:0] cutoff_reg = '0;
  logic signed [47:0] shift_reg = '0;

  pair_t pair_q[$];        // pairs waiting to be pushed
  result_t want_q[$];      // predicted results, oldest first
  logic req_taken = 1'b0;  // request accepted at the last rising edge
  logic idle_on = 1'b1;    // random bubbles on both sides
  logic hold_req = 1'b0;   // ask the result side for a long stall
  int push_gap = 0;
  int pop_gap = 0;
  int hold_cnt = 0;
  int bad_count = 0;
  int n_sent = 0;
  int n_got = 0;
  int n_used = 0;

  // (a*b) >> sh with saturation to all ones
  function automatic logic [63:0] mul_sat(logic [63:0] a, logic [63:0] b, int unsigned sh);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    p = p >> sh;
    return (p[127:64] != '0) ? '1 : p[63:0];
  endfunction

  // expected result of one neighbour pair under the current register values
  function automatic result_t lj_pair_result(pair_t p);
    result_t r;
    logic signed [31:0] dd[3];
    logic [63:0] mag_d[3];
    logic [63:0] r2, r2q, rinv2, rinv6, rinv12, v6, v12, gmag, afmag, mag;
    logic [64:0] num;
    logic gneg, neg;
    longint e, ev;
    logic signed [47:0] f;
    r = '0;
    r.index_i = p.atom_i;
    r.index_j = p.atom_j;
    dd[0] = p.disp_x;
    dd[1] = p.disp_y;
    dd[2] = p.disp_z;
    r2 = '0;
    for (int k = 0; k < 3; k++) begin
      mag_d[k] = dd[k] < 0 ? 64'(-longint'(dd[k])) : 64'(longint'(dd[k]));
      r2 += mag_d[k] * mag_d[k];
    end
    r2q = r2 >> (2 * DISP_FRAC_BITS - 32);
    // j below i, or at or beyond the cutoff: passed through unused
    if (p.atom_j < p.atom_i) return r;
    if (r2q >= ({32'd0, cutoff_reg} << 16)) return r;
    r.pair_used = 1'b1;
    if (r2q <= 1) begin
      rinv2 = '1;
    end else begin
      num = 65'd1 << 64;
      num = num / {1'b0, r2q};
      rinv2 = num[63:0];
    end
    rinv6 = mul_sat(mul_sat(rinv2, rinv2, 32), rinv2, 32);
    rinv12 = mul_sat(rinv6, rinv6, 32);
    v6 = mul_sat({16'd0, c6_reg}, rinv6, 32);
    v12 = mul_sat({16'd0, c12_reg}, rinv12, 32);
    e = longint'(v12 / 12) - longint'(v6 / 6);
    ev = (e >>> 8) - longint'(shift_reg);
    if (ev > longint'(48'sh7FFF_FFFF_FFFF)) ev = longint'(48'sh7FFF_FFFF_FFFF);
    if (ev < -longint'(64'h8000_0000_0000)) ev = -longint'(64'h8000_0000_0000);
    r.pair_energy = ev[47:0];
    gneg = v6 > v12;
    gmag = gneg ? v6 - v12 : v12 - v6;
    afmag = mul_sat(gmag, rinv2, 32);
    for (int k = 0; k < 3; k++) begin
      mag = mul_sat(afmag, mag_d[k], DISP_FRAC_BITS + 8);
      neg = gneg != (dd[k] < 0);
      if (neg) f = (mag >= 64'h8000_0000_0000) ? 48'sh8000_0000_0000 : -mag[47:0];
      else f = (mag > 64'h7FFF_FFFF_FFFF) ? 48'sh7FFF_FFFF_FFFF : mag[47:0];
      if (k == 0) r.force_x = f;
      else if (k == 1) r.force_y = f;
      else r.force_z = f;
    end
    return r;
  endfunction

  // request side: note acceptance, predict the result
  always @(posedge clk) begin
    req_taken = push && !full && !rst;
    if (req_taken) begin
      want_q.push_back(lj_pair_result(pair));
      n_sent++;
    end
  end

  // request driver, holds a request until it is taken
  always @(negedge clk) begin
    if (!rst) begin
      if (push && !req_taken) begin
        // keep offering the same pair
      end else if (push_gap > 0) begin
        push <= 1'b0;
        push_gap--;
      end else if (pair_q.size() > 0) begin
        if (idle_on && $urandom_range(0, 5) == 0) begin
          push <= 1'b0;
          push_gap = $urandom_range(0, 2);
        end else begin
          push <= 1'b1;
          pair <= pair_q.pop_front();
        end
      end else begin
        push <= 1'b0;
      end
    end
  end

  // long stall of the result side, counted in cycles
  always @(posedge clk) begin
    if (hold_req) begin
      hold_cnt = 300;
      hold_req = 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt--;
    end
  end

  // result driver with random bubbles, held off while the long stall runs
  always @(negedge clk) begin
    if (!rst) begin
      if (hold_cnt > 0) begin
        pop <= 1'b0;
      end else if (pop_gap > 0) begin
        pop <= 1'b0;
        pop_gap--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        pop <= 1'b0;
        pop_gap = $urandom_range(0, 2);
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // result checker, field by field against the oldest prediction
  always @(posedge clk) begin
    result_t want;
    if (!rst && pop && !empty) begin
      n_got++;
      if (want_q.size() == 0) begin
        bad_count++;
        if (bad_count <= 10)
          $display("unexpected result i=%0d j=%0d", result.index_i, result.index_j);
      end else begin
        want = want_q.pop_front();
        if (want.pair_used) n_used++;
        if (result.pair_used !== want.pair_used || result.index_i !== want.index_i ||
            result.index_j !== want.index_j || result.pair_energy !== want.pair_energy ||
            result.force_x !== want.force_x || result.force_y !== want.force_y ||
            result.force_z !== want.force_z) begin
          bad_count++;
          if (bad_count <= 10) begin
            $display("mismatch: exp used=%0b i=%0d j=%0d e=%h f=%h %h %h",
                     want.pair_used, want.index_i, want.index_j, want.pair_energy,
                     want.force_x, want.force_y, want.force_z);
            $display("          got used=%0b i=%0d j=%0d e=%h f=%h %h %h",
                     result.pair_used, result.index_i, result.index_j, result.pair_energy,
                     result.force_x, result.force_y, result.force_z);
          end
        end
      end
    end
  end

  // register write, only while nothing is in flight
  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [47:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_C6_SCALED: c6_reg = val;
      REG_C12_SCALED: c12_reg = val;
      REG_CUTOFF_SQ: cutoff_reg = val[31:0];
      default: shift_reg = val;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_regs(logic [47:0] c6, logic [47:0] c12, logic [31:0] cut,
                          logic [47:0] sh);
    write_reg(REG_C6_SCALED, c6);
    write_reg(REG_C12_SCALED, c12);
    write_reg(REG_CUTOFF_SQ, {16'd0, cut});
    write_reg(REG_ENERGY_SHIFT, sh);
  endtask

  task automatic drain();
    wait (pair_q.size() == 0 && !push && want_q.size() == 0);
    @(negedge clk);
  endtask

  task automatic add_pair(int unsigned ai, int unsigned aj, logic [31:0] dx, logic [31:0] dy,
                          logic [31:0] dz);
    pair_t p;
    p.atom_i = ai[11:0];
    p.atom_j = aj[11:0];
    p.disp_x = dx;
    p.disp_y = dy;
    p.disp_z = dz;
    pair_q.push_back(p);
  endtask

  // displacement component, mostly around the cutoff range
  function automatic logic [31:0] rand_disp(int unsigned mode);
    case (mode)
      0: return $urandom;
      1: return 32'(int'($urandom_range(0, 6 << 24)) - (3 << 24));
      2: return 32'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
      default: return 32'(int'($urandom_range(0, 1 << 27)) - (1 << 26));
    endcase
  endfunction

  task automatic add_random(int n);
    int unsigned ai, aj, m, sel;
    for (int k = 0; k < n; k++) begin
      sel = $urandom_range(0, 9);
      m = sel < 7 ? 1 : (sel == 7 ? 2 : (sel == 8 ? 0 : 3));
      ai = $urandom_range(0, 4095);
      sel = $urandom_range(0, 9);
      if (sel < 8) aj = $urandom_range(ai, 4095);
      else if (sel == 8) aj = ai;
      else aj = $urandom_range(0, 4095);
      add_pair(ai, aj, rand_disp(m), rand_disp(m), rand_disp(m));
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // registers straight out of reset: zero cutoff drops everything
    add_pair(0, 1, 32'h0100_0000, 0, 0);
    add_pair(3, 3, 0, 0, 0);
    add_pair(7, 4000, 32'h0000_0001, 32'hFFFF_FFFF, 0);
    drain();

    // directed pairs with unit parameters and a cutoff of 3.0
    set_regs(48'd24 << 32, 48'd48 << 32, 32'd9 << 16, 48'h0000_0100_0000);
    add_pair(0, 0, 0, 0, 0);                        // same atom, zero distance
    add_pair(0, 4095, 32'h0100_0000, 0, 0);         // index extremes
    add_pair(4095, 4095, 0, 0, 32'h0080_0000);
    add_pair(5, 3, 32'h0100_0000, 0, 0);            // j below i
    add_pair(10, 10, 32'h0300_0000, 0, 0);          // exactly on the cutoff
    add_pair(10, 11, 32'h02FF_FFFF, 0, 0);          // just inside
    add_pair(1, 2, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    add_pair(1, 2, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    add_pair(2, 3, -32'sh0100_0000, 32'h0100_0000, -32'sh0100_0000);
    add_pair(3, 4, 1, 1, 1);                        // tiny distance
    add_pair(3, 4, -1, -1, -1);
    add_pair(7, 8, 32'h0040_0000, 0, 0);            // strong repulsion
    add_pair(7, 9, 0, -32'sh0200_0000, 0);          // attraction
    add_pair(8, 9, 32'h00E0_0000, -32'sh00E0_0000, 32'h0010_0000);
    drain();

    // unit parameters, cutoff 2.5, with one long stall on the result side
    set_regs(48'd24 << 32, 48'd48 << 32, 32'd409600, 48'hFFFF_FFF0_0000);
    hold_req = 1'b1;
    add_random(260);
    drain();

    // every register at its maximum
    set_regs('1, '1, '1, 48'h7FFF_FFFF_FFFF);
    add_random(250);
    drain();

    // most negative shift, random coefficients and cutoff
    set_regs(48'({$urandom, $urandom}), 48'({$urandom, $urandom}), $urandom,
             48'h8000_0000_0000);
    add_random(250);
    drain();

    // zero coefficients: only the shift shows up
    set_regs('0, '0, 32'd16 << 16, 48'({$urandom, $urandom}));
    add_random(200);
    drain();

    // everything random
    set_regs(48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
             $urandom_range(1 << 16, 20 << 16), 48'({$urandom, $urandom}));
    add_random(250);
    drain();

    // final stretch at full rate, no bubbles on either side
    set_regs(48'd36 << 32, 48'd96 << 32, 32'd12 << 16, '0);
    idle_on = 1'b0;
    add_random(380);
    drain();

    repeat (120) @(posedge clk);
    if (want_q.size() != 0) bad_count += want_q.size();
    $display("pairs pushed %0d, results checked %0d, used %0d, mismatches %0d",
             n_sent, n_got, n_used, bad_count);
    $display("covered reset, max, min and random register settings and a full-queue stall");
    if (bad_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // hard stop if the block hangs
  initial begin
    #3000000;
    $display("FAILURE");
    $finish;
  end

endmodule
